/* hw/rtl/fds16_pkg.sv */
// Shared types and constants for the byte-serial frame parser.
package fds16_pkg;

    localparam logic [7:0]  HDR_BYTE = 8'h7E;
    localparam int          LEN_W    = 20;
    localparam logic [19:0] LEN_SAT  = 20'hFFFFF;
    localparam logic [19:0] LEN_BYTES = 20'd4;
    localparam int          TDATA_W  = 48;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD_SUM = 2'd2,
        KIND_TOO_BIG = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_CMDX = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUMH = 3'd5,
        PH_SUML = 3'd6
    } phase_t;

endpackage

/* hw/rtl/frame_deframer_sum16.sv */
// Frame parser: header hunt, command, command extension, length, payload and 16-bit sum check.
// A result is registered and appears on m_tvalid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register is refilled in the
// same cycle it is drained, so only downstream back-pressure stalls the input.
// Reset (aresetn low, synchronous): parser returns to header hunt, all sums and
// counters clear, max_len_reg returns to 0xFFFFF and the output empties.
module frame_deframer_sum16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // payload_byte[7:0], command[15:8], command_ext[23:16], payload_length[43:24], zero[47:44]
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data
);

    fds16_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  cmd_ext_reg, cmd_ext_next;
    logic [31:0] length_shift_reg, length_shift_next;
    logic [19:0] bytes_left_reg, bytes_left_next;
    logic [15:0] sum_acc_reg, sum_acc_next;
    logic [7:0]  sum_high_rx_reg, sum_high_rx_next;
    logic [19:0] max_len_reg;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    fds16_pkg::kind_t m_kind_reg;
    logic        m_tlast_reg;

    logic        in_acc;
    logic [15:0] sum_plus;
    logic [31:0] len_full;
    logic        too_big;
    logic [19:0] bytes_dec;
    logic [19:0] len_sat;
    logic        res_emit;
    fds16_pkg::kind_t res_kind;
    logic [7:0]  res_byte;
    logic        res_last;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    assign sum_plus  = sum_acc_reg + {8'h00, s_tdata};
    assign len_full  = {length_shift_reg[23:0], s_tdata};
    assign too_big   = (|len_full[31:20]) || (len_full[19:0] > max_len_reg);
    assign bytes_dec = bytes_left_reg - 20'd1;

    always_comb begin
        phase_next        = phase_reg;
        cmd_next          = cmd_reg;
        cmd_ext_next      = cmd_ext_reg;
        length_shift_next = length_shift_reg;
        bytes_left_next   = bytes_left_reg;
        sum_acc_next      = sum_acc_reg;
        sum_high_rx_next  = sum_high_rx_reg;
        case (phase_reg)
            fds16_pkg::PH_HUNT: begin
                if (s_tdata == fds16_pkg::HDR_BYTE) begin
                    sum_acc_next = {8'h00, fds16_pkg::HDR_BYTE};
                    phase_next   = fds16_pkg::PH_CMD;
                end
            end
            fds16_pkg::PH_CMD: begin
                cmd_next     = s_tdata;
                sum_acc_next = sum_plus;
                phase_next   = fds16_pkg::PH_CMDX;
            end
            fds16_pkg::PH_CMDX: begin
                cmd_ext_next      = s_tdata;
                sum_acc_next      = sum_plus;
                length_shift_next = 32'd0;
                bytes_left_next   = fds16_pkg::LEN_BYTES;
                phase_next        = fds16_pkg::PH_LEN;
            end
            fds16_pkg::PH_LEN: begin
                length_shift_next = len_full;
                sum_acc_next      = sum_plus;
                bytes_left_next   = bytes_dec;
                if (bytes_dec == 20'd0) begin
                    if (too_big) begin
                        phase_next = fds16_pkg::PH_HUNT;
                    end else begin
                        bytes_left_next = len_full[19:0];
                        phase_next      = (len_full[19:0] == 20'd0) ? fds16_pkg::PH_SUMH
                                                                    : fds16_pkg::PH_DATA;
                    end
                end
            end
            fds16_pkg::PH_DATA: begin
                sum_acc_next    = sum_plus;
                bytes_left_next = bytes_dec;
                if (bytes_dec == 20'd0) begin
                    phase_next = fds16_pkg::PH_SUMH;
                end
            end
            fds16_pkg::PH_SUMH: begin
                sum_high_rx_next = s_tdata;
                phase_next       = fds16_pkg::PH_SUML;
            end
            fds16_pkg::PH_SUML: begin
                phase_next = fds16_pkg::PH_HUNT;
            end
            default: begin
                phase_next = fds16_pkg::PH_HUNT;
            end
        endcase
    end

    // Result selection for the byte in flight.
    always_comb begin
        res_emit = 1'b0;
        res_kind = fds16_pkg::KIND_PAYLOAD;
        res_byte = 8'h00;
        res_last = 1'b0;
        case (phase_reg)
            fds16_pkg::PH_LEN: begin
                if (bytes_dec == 20'd0 && too_big) begin
                    res_emit = 1'b1;
                    res_kind = fds16_pkg::KIND_TOO_BIG;
                    res_last = 1'b1;
                end
            end
            fds16_pkg::PH_DATA: begin
                res_emit = 1'b1;
                res_byte = s_tdata;
            end
            fds16_pkg::PH_SUML: begin
                res_emit = 1'b1;
                res_last = 1'b1;
                res_kind = ({sum_high_rx_reg, s_tdata} == sum_acc_reg) ? fds16_pkg::KIND_GOOD
                                                                      : fds16_pkg::KIND_BAD_SUM;
            end
            default: begin
                res_emit = 1'b0;
            end
        endcase
    end

    assign len_sat = (|length_shift_next[31:20]) ? fds16_pkg::LEN_SAT : length_shift_next[19:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= fds16_pkg::PH_HUNT;
            cmd_reg          <= 8'h00;
            cmd_ext_reg      <= 8'h00;
            length_shift_reg <= 32'd0;
            bytes_left_reg   <= 20'd0;
            sum_acc_reg      <= 16'h0000;
            sum_high_rx_reg  <= 8'h00;
        end else if (in_acc) begin
            phase_reg        <= phase_next;
            cmd_reg          <= cmd_next;
            cmd_ext_reg      <= cmd_ext_next;
            length_shift_reg <= length_shift_next;
            bytes_left_reg   <= bytes_left_next;
            sum_acc_reg      <= sum_acc_next;
            sum_high_rx_reg  <= sum_high_rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= fds16_pkg::LEN_SAT;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_acc && res_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && res_emit) begin
            m_tdata_reg <= {4'h0, len_sat, cmd_ext_next, cmd_next, res_byte};
            m_kind_reg  <= res_kind;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hw/rtl/fds16_chk.sv */
// Port-level checker for the frame parser, bound into frame_deframer_sum16.
module fds16_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // The output register empties on reset.
    a_reset_empty: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // Only payload transactions are non-final, and they alone carry a data byte.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != fds16_pkg::KIND_PAYLOAD)))
        else $error("tlast disagrees with result kind");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != fds16_pkg::KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'h00))
        else $error("frame-end result carries a data byte");

    // An empty or draining output register never blocks the input.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind frame_deframer_sum16 fds16_chk u_fds16_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/frame_deframer_sum16_tb.sv */
// Self-checking testbench for the byte-serial frame parser with 16-bit sum check.
`timescale 1ns / 1ps

localparam int MAX_REPORTS = 100;

typedef struct {
    fds16_pkg::kind_t kind;
    logic [7:0]       data;
    logic [7:0]       cmd;
    logic [7:0]       cmd_ext;
    logic [19:0]      len;
    logic             last;
} frame_result_t;

class frame_scoreboard;
    logic [19:0]       max_len;
    fds16_pkg::phase_t ph;
    logic [7:0]        cmd_q;
    logic [7:0]        cmd_ext_q;
    logic [7:0]        sum_hi;
    logic [31:0]       len_acc;
    logic [19:0]       left;
    logic [15:0]       csum;
    frame_result_t     exp_q[$];
    int                errors;

    function new();
        max_len   = fds16_pkg::LEN_SAT;
        ph        = fds16_pkg::PH_HUNT;
        cmd_q     = '0;
        cmd_ext_q = '0;
        sum_hi    = '0;
        len_acc   = '0;
        left      = '0;
        csum      = '0;
        errors    = 0;
    endfunction

    function void set_limit(logic [19:0] v);
        max_len = v;
    endfunction

    function bit hunting();
        return ph == fds16_pkg::PH_HUNT;
    endfunction

    function int pending();
        return exp_q.size();
    endfunction

    function void push_result(fds16_pkg::kind_t k, logic [7:0] b, logic last);
        frame_result_t e;
        e.kind    = k;
        e.data    = b;
        e.cmd     = cmd_q;
        e.cmd_ext = cmd_ext_q;
        e.len     = (len_acc > {12'd0, fds16_pkg::LEN_SAT}) ? fds16_pkg::LEN_SAT
                                                            : len_acc[19:0];
        e.last    = last;
        exp_q.push_back(e);
    endfunction

    // Advances the parser by one accepted byte and queues the result it causes.
    function void note_byte(logic [7:0] b);
        case (ph)
            fds16_pkg::PH_HUNT: begin
                if (b == fds16_pkg::HDR_BYTE) begin
                    csum = {8'd0, fds16_pkg::HDR_BYTE};
                    ph   = fds16_pkg::PH_CMD;
                end
            end
            fds16_pkg::PH_CMD: begin
                cmd_q = b;
                csum  = csum + {8'd0, b};
                ph    = fds16_pkg::PH_CMDX;
            end
            fds16_pkg::PH_CMDX: begin
                cmd_ext_q = b;
                csum      = csum + {8'd0, b};
                len_acc   = '0;
                left      = fds16_pkg::LEN_BYTES;
                ph        = fds16_pkg::PH_LEN;
            end
            fds16_pkg::PH_LEN: begin
                len_acc = {len_acc[23:0], b};
                csum    = csum + {8'd0, b};
                left    = left - 20'd1;
                if (left == 0) begin
                    // The length is unsigned 32 bits, so a set top bit always aborts.
                    if (len_acc > {12'd0, max_len}) begin
                        ph = fds16_pkg::PH_HUNT;
                        push_result(fds16_pkg::KIND_TOO_BIG, 8'd0, 1'b1);
                    end else begin
                        left = len_acc[19:0];
                        ph   = (left == 0) ? fds16_pkg::PH_SUMH : fds16_pkg::PH_DATA;
                    end
                end
            end
            fds16_pkg::PH_DATA: begin
                csum = csum + {8'd0, b};
                left = left - 20'd1;
                if (left == 0) ph = fds16_pkg::PH_SUMH;
                push_result(fds16_pkg::KIND_PAYLOAD, b, 1'b0);
            end
            fds16_pkg::PH_SUMH: begin
                sum_hi = b;
                ph     = fds16_pkg::PH_SUML;
            end
            fds16_pkg::PH_SUML: begin
                ph = fds16_pkg::PH_HUNT;
                push_result(({sum_hi, b} == csum) ? fds16_pkg::KIND_GOOD
                                                  : fds16_pkg::KIND_BAD_SUM,
                            8'd0, 1'b1);
            end
            default: ph = fds16_pkg::PH_HUNT;
        endcase
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, logic [47:0] tdata, logic last);
        frame_result_t e;
        if (exp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d tdata %h", kind, tdata));
            return;
        end
        e = exp_q.pop_front();
        if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, e.kind));
        if (tdata[7:0] !== e.data)
            report_mismatch($sformatf("payload byte %h, expected %h", tdata[7:0], e.data));
        if (tdata[15:8] !== e.cmd)
            report_mismatch($sformatf("command %h, expected %h", tdata[15:8], e.cmd));
        if (tdata[23:16] !== e.cmd_ext)
            report_mismatch($sformatf("command_ext %h, expected %h", tdata[23:16], e.cmd_ext));
        if (tdata[43:24] !== e.len)
            report_mismatch($sformatf("payload length %h, expected %h", tdata[43:24], e.len));
        if (tdata[47:44] !== 4'd0)
            report_mismatch($sformatf("padding bits %h, expected zero", tdata[47:44]));
        if (last !== e.last)
            report_mismatch($sformatf("tlast %b, expected %b", last, e.last));
    endtask
endclass

module frame_deframer_sum16_tb;

    localparam real CLK_PERIOD     = 10.0;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  LONG_HOLD      = 120;
    localparam int  PHASE_BYTES    = 250;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [19:0] cfg_wr_data = 20'd0;

    frame_scoreboard sb;
    logic [19:0]     cur_limit   = fds16_pkg::LEN_SAT;
    bit              quiet       = 1'b0;
    bit              hold_req    = 1'b0;
    int              frame_bytes = 0;
    int              idle_cycles = 0;

    frame_deframer_sum16 dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Input notes come first so a result in the same cycle as its byte would still find its expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[frame_deframer_sum16] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random back-pressure bursts, plus one long hold on request.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drops valid and waits until every queued result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [19:0] v);
        wait_idle();
        while (!sb.hunting()) begin
            send_byte(8'h00);
            wait_idle();
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(v);
        cur_limit = v;
    endtask

    // Builds and sends one frame; a keep from 0 up to below the full size cuts it short, fill < 0 means random data.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] cmd_ext,
                              input logic [31:0] len, input int n_data, input bit with_sum,
                              input logic [15:0] sum_flip, input int keep, input int fill);
        logic [7:0]  fb[$];
        logic [15:0] csum;
        logic [7:0]  b;
        int          i;
        int          n_send;
        fb = {fds16_pkg::HDR_BYTE, cmd, cmd_ext,
              len[31:24], len[23:16], len[15:8], len[7:0]};
        for (i = 0; i < n_data; i++) begin
            if (fill >= 0) b = 8'(fill);
            else b = ($urandom_range(0, 7) == 0) ? fds16_pkg::HDR_BYTE : 8'($urandom);
            fb.push_back(b);
        end
        csum = '0;
        for (i = 0; i < fb.size(); i++) csum = csum + {8'd0, fb[i]};
        csum = csum ^ sum_flip;
        if (with_sum) begin
            fb.push_back(csum[15:8]);
            fb.push_back(csum[7:0]);
        end
        n_send = (keep >= 0 && keep < fb.size()) ? keep : fb.size();
        for (i = 0; i < n_send; i++) send_byte(fb[i]);
        frame_bytes += n_send;
    endtask

    function automatic logic [31:0] pick_len();
        int          r;
        logic [31:0] cap;
        logic [31:0] n;
        cap = (cur_limit > 20'd300) ? 32'd300 : {12'd0, cur_limit};
        r = $urandom_range(0, 99);
        if (r < 70)      n = $urandom_range(0, 12);
        else if (r < 90) n = $urandom_range(13, 60);
        else if (r < 97) n = cap;
        else             n = $urandom_range(100, 300);
        if (n > cap) n = $urandom_range(0, cap);
        return n;
    endfunction

    function automatic logic [31:0] pick_too_big();
        case ($urandom_range(0, 3))
            0:       return {1'b1, 31'($urandom)};
            1:       return {12'd0, cur_limit} + 32'd1;
            2:       return {12'd0, cur_limit} + 32'd1 + $urandom_range(0, 1000);
            default: return $urandom | 32'h0010_0000;
        endcase
    endfunction

    task automatic run_phase(input int n_bytes);
        int          stop;
        int          r;
        int          keep;
        logic [31:0] len;
        logic [7:0]  cmd;
        logic [7:0]  cmd_ext;
        logic [7:0]  b;
        logic [15:0] flip;
        stop = frame_bytes + n_bytes;
        while (frame_bytes < stop) begin
            r       = $urandom_range(0, 99);
            cmd     = 8'($urandom);
            cmd_ext = 8'($urandom);
            if (r < 8) begin
                // Line noise between frames; no header byte, so it is ignored while the parser hunts.
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom);
                    if (b == fds16_pkg::HDR_BYTE) b = ~b;
                    send_byte(b);
                end
            end else if (r < 20) begin
                send_frame(cmd, cmd_ext, pick_too_big(), 0, 1'b0, 16'd0, -1, -1);
            end else begin
                len  = pick_len();
                flip = 16'd0;
                keep = -1;
                if (r < 35) flip = 16'($urandom_range(1, 16'hFFFF));
                else if (r < 45) keep = $urandom_range(7, 8 + int'(len));
                send_frame(cmd, cmd_ext, len, int'(len), 1'b1, flip, keep, -1);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_limit(fds16_pkg::LEN_SAT);
        send_byte(8'h00);
        send_frame(8'hFF, 8'h00, 32'd1, 1, 1'b1, 16'd0, -1, fds16_pkg::HDR_BYTE);
        send_frame(8'h00, 8'hFF, 32'h8000_0000, 0, 1'b0, 16'd0, -1, -1);
        send_frame(8'h01, 8'h02, 32'd0, 0, 1'b1, 16'h0100, -1, -1);

        write_limit(20'd0);
        run_phase(PHASE_BYTES);

        // The receiver stalls for a long stretch while frames keep coming.
        write_limit(20'd20);
        hold_req = 1'b1;
        run_phase(PHASE_BYTES);

        write_limit(20'($urandom_range(1, 64)));
        run_phase(PHASE_BYTES / 2);
        wait_idle();
        run_phase(PHASE_BYTES / 2);

        write_limit(20'($urandom_range(0, fds16_pkg::LEN_SAT)));
        run_phase(PHASE_BYTES);

        write_limit(fds16_pkg::LEN_SAT);
        quiet = 1'b1;
        run_phase(PHASE_BYTES);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[frame_deframer_sum16] OK");
        end else begin
            $display("[frame_deframer_sum16] ERROR");
        end
        $finish;
    end

endmodule

/* frame_deframer_sum16.f */
hw/rtl/fds16_pkg.sv
hw/rtl/frame_deframer_sum16.sv
hw/rtl/fds16_chk.sv
tb/sv/frame_deframer_sum16_tb.sv
